// File: design/slee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite list entry expander package
// Shared constants, register indexes and the descriptor handed from the
// front part to the back part.
// ----------------------------------------------------------------------------
package slee_pkg;

  localparam int SLEE_QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_X_ADJUST = 2'd0;
  localparam logic [1:0] REG_Y_ADJUST = 2'd1;

  localparam logic [5:0] X_ADJUST_RESET = 6'h3c;  // -4
  localparam logic [5:0] Y_ADJUST_RESET = 6'h00;

  // Entry word fields.
  localparam int FLASH_BIT    = 12;
  localparam int STEP_DOWN_BIT = 14;

  // Screen geometry: the wrap thresholds are 9-bit unsigned, the rest 11-bit signed.
  localparam logic signed [10:0] POS_WRAP    = 11'sd512;
  localparam logic [8:0]         X_WRAP_AT   = 9'd320;
  localparam logic [8:0]         Y_WRAP_AT   = 9'd256;
  localparam logic signed [10:0] X_MIRROR    = 11'sd304;
  localparam logic signed [10:0] Y_MIRROR    = 11'sd240;
  localparam logic signed [10:0] BORDER      = 11'sd16;
  localparam logic signed [10:0] Y_BIAS      = 11'sd9;    // border minus seven
  localparam logic signed [10:0] X_LIMIT     = 11'sd336;  // width plus border
  localparam logic signed [10:0] Y_LIMIT     = 11'sd256;  // height plus border
  localparam logic signed [10:0] CELL_PX     = 11'sd16;
  localparam logic signed [10:0] Y_LAST_FROM = 11'sd240;  // Y_LIMIT - CELL_PX

  typedef struct packed {
    logic [16:0]        tile_start;
    logic               step_down;
    logic [8:0]         xdraw;
    logic signed [10:0] y_start;
    logic [2:0]         multi;
    logic [3:0]         palette;
    logic [1:0]         flip;
  } slee_desc_t;

endpackage

// File: design/sprite_list_entry_expander_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite list entry expander
// Expands three-word sprite list entries into per-cell placement commands.
// ----------------------------------------------------------------------------
// The front part takes one entry per cycle whenever its descriptor queue has
// room; unused, flashing-on-odd-frame and horizontally off-screen entries are
// dropped there. A kept entry waits in the queue until the back part takes
// it, and the back part then walks the cells of the sprite (1, 2, 4 or 8),
// one per cycle unless the output stalls, emitting a command for each
// vertically visible cell. The cell walk of the back part sets the sustained
// rate. Configuration writes are always taken (ready is held high); write
// them only while the block is idle.
// ----------------------------------------------------------------------------
module sprite_list_entry_expander_top import slee_pkg::*; #(
  parameter int QUEUE_DEPTH = SLEE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        entry_valid,
  output logic        entry_stall,
  input  logic        first_of_frame,
  input  logic [15:0] attr_y_word,
  input  logic [15:0] tile_word,
  input  logic [15:0] attr_x_word,
  output logic        cmd_valid,
  input  logic        cmd_stall,
  output logic [16:0] tile_number,
  output logic [8:0]  screen_x,
  output logic [7:0]  screen_y,
  output logic [3:0]  palette,
  output logic [1:0]  flip,
  output logic        last
);

  logic [5:0] x_adjust;
  logic [5:0] y_adjust;
  logic       push;
  logic       queue_full;
  logic       pop;
  logic       desc_ready;
  slee_desc_t front_desc;
  slee_desc_t back_desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_adjust <= X_ADJUST_RESET;
      y_adjust <= Y_ADJUST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_X_ADJUST) begin
        x_adjust <= cfg_data;
      end else if (cfg_index == REG_Y_ADJUST) begin
        y_adjust <= cfg_data;
      end
    end
  end

  slee_front u_front (
    .clk            (clk),
    .rst            (rst),
    .entry_valid    (entry_valid),
    .entry_stall    (entry_stall),
    .first_of_frame (first_of_frame),
    .attr_y_word    (attr_y_word),
    .tile_word      (tile_word),
    .attr_x_word    (attr_x_word),
    .x_adjust       (x_adjust),
    .y_adjust       (y_adjust),
    .queue_full     (queue_full),
    .push           (push),
    .desc           (front_desc)
  );

  slee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_desc),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (desc_ready),
    .pop_data  (back_desc)
  );

  slee_back u_back (
    .clk         (clk),
    .rst         (rst),
    .desc_ready  (desc_ready),
    .desc        (back_desc),
    .pop         (pop),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .tile_number (tile_number),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .palette     (palette),
    .flip        (flip),
    .last        (last)
  );

endmodule

// File: design/slee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite list entry expander, front part
// Accepts entries, keeps the frame parity, drops unused, odd-frame flashing
// and horizontally off-screen entries and queues a descriptor for the rest.
// ----------------------------------------------------------------------------
module slee_front import slee_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             entry_valid,
  output logic             entry_stall,
  input  logic             first_of_frame,
  input  logic [15:0]      attr_y_word,
  input  logic [15:0]      tile_word,
  input  logic [15:0]      attr_x_word,
  input  logic [5:0]       x_adjust,
  input  logic [5:0]       y_adjust,
  input  logic             queue_full,
  output logic             push,
  output slee_desc_t       desc
);

  logic               parity;
  logic               parity_next;
  logic               accept;
  logic               keep;
  logic [2:0]         multi;
  logic signed [10:0] xpos;
  logic signed [10:0] ypos;
  logic signed [10:0] xdraw;
  logic signed [10:0] xadj;
  logic signed [10:0] yadj;

  assign entry_stall = queue_full;
  assign accept      = entry_valid && !entry_stall;
  assign parity_next = parity ^ first_of_frame;

  assign xadj  = $signed({{5{x_adjust[5]}}, x_adjust});
  assign yadj  = $signed({{5{y_adjust[5]}}, y_adjust});
  assign multi = 3'((4'd1 << attr_y_word[10:9]) - 4'd1);

  always_comb begin
    xpos = $signed({2'b00, attr_x_word[8:0]});
    if (attr_x_word[8:0] >= X_WRAP_AT) begin
      xpos = xpos - POS_WRAP;
    end
    ypos = $signed({2'b00, attr_y_word[8:0]});
    if (attr_y_word[8:0] >= Y_WRAP_AT) begin
      ypos = ypos - POS_WRAP;
    end
  end

  assign xdraw = X_MIRROR - xpos + BORDER + xadj;

  always_comb begin
    desc.step_down  = attr_y_word[STEP_DOWN_BIT];
    desc.tile_start = attr_y_word[STEP_DOWN_BIT] ? {1'b0, tile_word} + {14'd0, multi}
                                                 : {1'b0, tile_word};
    desc.xdraw      = xdraw[8:0];
    // Top cell position; the back part walks downward from here.
    desc.y_start    = Y_MIRROR - ypos + Y_BIAS + yadj - $signed({4'b0000, multi, 4'b0000});
    desc.multi      = multi;
    desc.palette    = attr_x_word[12:9];
    desc.flip       = attr_y_word[14:13];
  end

  assign keep = (tile_word != 16'd0) &&
                !(attr_y_word[FLASH_BIT] && parity_next) &&
                (xdraw > 11'sd0) && (xdraw < X_LIMIT);

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else if (accept) begin
      parity <= parity_next;
    end
  end

endmodule

// File: design/slee_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite list entry expander, descriptor queue
// Small first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module slee_queue import slee_pkg::*; #(
  parameter int DEPTH = SLEE_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  slee_desc_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output slee_desc_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  slee_desc_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/slee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite list entry expander, back part
// Walks the cells of one queued sprite from top to bottom, one cell per cycle
// unless stalled, emitting a placement command for each vertically visible cell.
// ----------------------------------------------------------------------------
module slee_back import slee_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        desc_ready,
  input  slee_desc_t  desc,
  output logic        pop,
  output logic        cmd_valid,
  input  logic        cmd_stall,
  output logic [16:0] tile_number,
  output logic [8:0]  screen_x,
  output logic [7:0]  screen_y,
  output logic [3:0]  palette,
  output logic [1:0]  flip,
  output logic        last
);

  logic               busy;
  logic [2:0]         m;
  logic [2:0]         multi;
  logic signed [10:0] ycur;
  logic [16:0]        tno;
  logic               step_down;
  logic [8:0]         xdraw;
  logic [3:0]         pal;
  logic [1:0]         flp;
  logic               advance;
  logic               visible;
  logic               is_last;

  assign pop     = !busy && desc_ready;
  assign advance = busy && (!cmd_valid || !cmd_stall);
  assign visible = (ycur > 11'sd0) && (ycur < Y_LIMIT);
  // Visible cells are contiguous, so the next cell down being clipped ends the run.
  assign is_last = (m == 3'd0) || (ycur >= Y_LAST_FROM);

  always_ff @(posedge clk) begin
    if (pop) begin
      tno       <= desc.tile_start;
      step_down <= desc.step_down;
      xdraw     <= desc.xdraw;
      ycur      <= desc.y_start;
      m         <= desc.multi;
      multi     <= desc.multi;
      pal       <= desc.palette;
      flp       <= desc.flip;
    end else if (advance) begin
      tno  <= step_down ? tno - 17'd1 : tno + 17'd1;
      ycur <= ycur + CELL_PX;
      m    <= m - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && (m == 3'd0)) begin
        busy <= 1'b0;
      end
      if (advance && visible) begin
        cmd_valid <= 1'b1;
      end else if (!cmd_stall) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && visible) begin
      tile_number <= tno;
      screen_x    <= xdraw;
      screen_y    <= ycur[7:0];
      palette     <= pal;
      flip        <= flp;
      last        <= is_last;
    end
  end

  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (m <= multi))
    else $error("cell counter beyond sprite height");

  a_visible_only: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (screen_y != 8'd0))
    else $error("command issued for a clipped cell");

  a_load_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd_valid) |-> $past(busy))
    else $error("command issued while no sprite in progress");

  a_no_pop_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pop)
    else $error("descriptor taken while a sprite is in progress");

endmodule

// File: dv/sprite_list_entry_expander_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite list entry expander testbench
// Sends sprite list entries with random gaps and takes placement commands
// with random stalls. Each command is checked field by field against an
// in-bench expansion of the entry. Directed entries cover the unused and
// flashing cases, every height and flip, the wrap and clip edges, and the
// tile count past 16 bits. Random traffic then runs under several offset
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module sprite_list_entry_expander_top_tb;
  import slee_pkg::*;

  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [16:0] tile_no;
    logic [8:0]  sx;
    logic [7:0]  sy;
    logic [3:0]  pal;
    logic [1:0]  flp;
    logic        lst;
  } cell_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;
  logic        entry_valid = 1'b0;
  logic        entry_stall;
  logic        first_of_frame = 1'b0;
  logic [15:0] attr_y_word = '0;
  logic [15:0] tile_word = '0;
  logic [15:0] attr_x_word = '0;
  logic        cmd_valid;
  logic        cmd_stall = 1'b0;
  logic [16:0] tile_number;
  logic [8:0]  screen_x;
  logic [7:0]  screen_y;
  logic [3:0]  palette;
  logic [1:0]  flip;
  logic        last;

  // Bench copy of the block's state and registers.
  logic              frame_odd = 1'b0;
  logic signed [5:0] x_shift = X_ADJUST_RESET;
  logic signed [5:0] y_shift = Y_ADJUST_RESET;

  cell_cmd_t pending_cmds[$];
  int        mismatches = 0;
  int        stall_left = 0;
  int        last_cmd_count = 0;
  bit        full_rate = 1'b0;

  sprite_list_entry_expander_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .entry_valid    (entry_valid),
    .entry_stall    (entry_stall),
    .first_of_frame (first_of_frame),
    .attr_y_word    (attr_y_word),
    .tile_word      (tile_word),
    .attr_x_word    (attr_x_word),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .tile_number    (tile_number),
    .screen_x       (screen_x),
    .screen_y       (screen_y),
    .palette        (palette),
    .flip           (flip),
    .last           (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("sprite_list_entry_expander_top_tb: done, errors");
    $finish;
  end

  // Expands one accepted entry into the commands it should produce and
  // returns how many there are.
  function automatic int expand_entry(bit fof, logic [15:0] ay, logic [15:0] tw,
                                      logic [15:0] ax);
    int xpos, ypos, xdraw, ydraw, multi, m, count;
    cell_cmd_t c;
    count = 0;
    if (fof) frame_odd = ~frame_odd;
    if (tw == 16'd0) return 0;
    if (ay[FLASH_BIT] && frame_odd) return 0;
    multi = (1 << ay[10:9]) - 1;
    xpos = int'(ax[8:0]);
    ypos = int'(ay[8:0]);
    if (xpos >= 320) xpos -= 512;
    if (ypos >= 256) ypos -= 512;
    xpos = 304 - xpos;
    ypos = 240 - ypos;
    xdraw = xpos + 16 + int'(x_shift);
    if (xdraw <= 0 || xdraw >= 336) return 0;
    for (m = multi; m >= 0; m--) begin
      ydraw = ypos - 16 * m + 9 + int'(y_shift);
      if (ydraw <= 0 || ydraw >= 256) continue;
      c.tile_no = 17'(tw) + 17'(ay[STEP_DOWN_BIT] ? m : multi - m);
      c.sx = xdraw[8:0];
      c.sy = ydraw[7:0];
      c.pal = ax[12:9];
      c.flp = ay[14:13];
      c.lst = 1'b0;
      pending_cmds.push_back(c);
      count++;
    end
    if (count > 0) pending_cmds[pending_cmds.size() - 1].lst = 1'b1;
    return count;
  endfunction

  function automatic void note_mismatch(string what, cell_cmd_t want, cell_cmd_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: want tile %h x %0d y %0d pal %0d flip %0d last %0b",
               $realtime, what, want.tile_no, want.sx, want.sy, want.pal, want.flp,
               want.lst);
      $display("%0t %s: got  tile %h x %0d y %0d pal %0d flip %0d last %0b",
               $realtime, what, got.tile_no, got.sx, got.sy, got.pal, got.flp,
               got.lst);
    end
  endfunction

  function automatic void check_command();
    cell_cmd_t got, want;
    got.tile_no = tile_number;
    got.sx = screen_x;
    got.sy = screen_y;
    got.pal = palette;
    got.flp = flip;
    got.lst = last;
    if (pending_cmds.size() == 0) begin
      note_mismatch("command with none expected", '0, got);
    end else begin
      want = pending_cmds.pop_front();
      if (got.tile_no !== want.tile_no || got.sx !== want.sx || got.sy !== want.sy ||
          got.pal !== want.pal || got.flp !== want.flp || got.lst !== want.lst)
        note_mismatch("command mismatch", want, got);
    end
  endfunction

  // Command side: checks each accepted command, then stalls for a drawn count.
  always @(posedge clk) begin
    if (rst) begin
      cmd_stall <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        check_command();
        stall_left = full_rate ? 0 : $urandom_range(0, 11);
      end
      cmd_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Valid is left high after a request so that back-to-back requests never
  // lower and raise it in the same step.
  task automatic send_entry(bit fof, logic [15:0] ay, logic [15:0] tw, logic [15:0] ax);
    int gap;
    gap = full_rate ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      entry_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    entry_valid <= 1'b1;
    first_of_frame <= fof;
    attr_y_word <= ay;
    tile_word <= tw;
    attr_x_word <= ax;
    @(posedge clk);
    while (entry_stall) @(posedge clk);
    last_cmd_count = expand_entry(fof, ay, tw, ax);
  endtask

  // Waits until every expected command has come and dropped entries have
  // drained out of the pipeline.
  task automatic quiesce();
    entry_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_ADJUST: x_shift = data;
      REG_Y_ADJUST: y_shift = data;
      default: ;
    endcase
  endtask

  // A write to a spare index goes in between; the block must ignore it.
  task automatic configure(int x_adj, int y_adj);
    quiesce();
    write_reg(REG_X_ADJUST, x_adj[5:0]);
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 6'($urandom));
    write_reg(REG_Y_ADJUST, y_adj[5:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_unused_entries();
    send_entry(1'b1, 16'hffff, 16'h0000, 16'hffff);
    send_entry(1'b0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // Parity is odd here after the first unused entry.
  task automatic test_flash_parity();
    send_entry(1'b0, 16'h1064, 16'h0010, 16'h0064);
    send_entry(1'b0, 16'h0064, 16'h0020, 16'h0064);
    send_entry(1'b1, 16'h1064, 16'h0030, 16'h0064);
    send_entry(1'b1, 16'h1064, 16'h0040, 16'h0064);
    send_entry(1'b1, 16'h0050, 16'h0050, 16'h0050);
  endtask

  task automatic test_heights_and_flips();
    int h;
    logic [15:0] ay, ax;
    for (h = 0; h < 4; h++) begin
      ay = 16'h0050;
      ay[10:9] = h[1:0];
      ay[14:13] = h[1:0];
      ax = 16'h0080;
      ax[12:9] = (h % 2 == 0) ? 4'h0 : 4'hf;
      send_entry(1'b0, ay, 16'h0100 + 16'(h), ax);
    end
    // Tallest sprite stepping down from the top tile code, spare bits all set.
    send_entry(1'b0, 16'hee40, 16'hffff, 16'hfe80);
  endtask

  // With the reset offset, raw x 315 and 493 are the last kept columns.
  task automatic test_position_edges();
    send_entry(1'b0, 16'h0030, 16'h0200, 16'h013b);
    send_entry(1'b0, 16'h0230, 16'h0201, 16'h013c);
    send_entry(1'b0, 16'h0430, 16'h0202, 16'h01ec);
    send_entry(1'b0, 16'h0630, 16'h0203, 16'h01ed);
    send_entry(1'b0, 16'h0000, 16'h0204, 16'h0000);
    send_entry(1'b0, 16'h06ff, 16'h0205, 16'h01ff);
    send_entry(1'b0, 16'h0700, 16'h0206, 16'h0140);
    send_entry(1'b0, 16'h07ff, 16'h0207, 16'h0100);
  endtask

  task automatic random_entry();
    bit fof;
    logic [15:0] ay, tw, ax;
    fof = ($urandom_range(0, 9) == 0);
    ay = 16'($urandom);
    ax = 16'($urandom);
    if ($urandom_range(0, 3) != 0) ay[8:0] = 9'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) ax[8:0] = 9'($urandom_range(0, 319));
    case ($urandom_range(0, 9))
      0: tw = 16'h0000;
      1: tw = 16'hffff - 16'($urandom_range(0, 7));
      default: tw = 16'($urandom);
    endcase
    send_entry(fof, ay, tw, ax);
  endtask

  // Random entries until n_shown of them have produced commands.
  task automatic test_random_traffic(int n_shown, bit pause_midway);
    int shown, sent;
    shown = 0;
    sent = 0;
    while (shown < n_shown) begin
      if (sent % 16 == 0) full_rate = ($urandom_range(0, 3) == 0);
      random_entry();
      if (last_cmd_count > 0) shown++;
      sent++;
      if (pause_midway && shown == n_shown / 2 && last_cmd_count > 0) quiesce();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unused_entries();
    test_flash_parity();
    test_heights_and_flips();
    test_position_edges();
    test_random_traffic(15, 1'b1);
    configure(-16, -16);
    test_random_traffic(15, 1'b0);
    configure(16, 16);
    test_random_traffic(20, 1'b1);
    configure(-32, 31);
    test_random_traffic(15, 1'b0);
    configure(31, -32);
    test_random_traffic(15, 1'b0);
    configure($urandom_range(0, 32) - 16, $urandom_range(0, 32) - 16);
    test_random_traffic(15, 1'b0);
    quiesce();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("sprite_list_entry_expander_top_tb: done, clean");
    end else begin
      $display("sprite_list_entry_expander_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
design/slee_pkg.sv
design/slee_front.sv
design/slee_queue.sv
design/slee_back.sv
design/sprite_list_entry_expander_top.sv
dv/sprite_list_entry_expander_top_tb.sv
